[design/string_escape_decoder_top_macros.svh]
// Assertion macros shared by the checker of the string escape decoder.
// Depends on a clock clk_i and an active-low reset rst_ni in the using scope.
`ifndef STRING_ESCAPE_DECODER_TOP_MACROS_SVH
`define STRING_ESCAPE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define SED_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("string escape decoder check failed");

// Next-cycle implication, checked out of reset
`define SED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("string escape decoder check failed");

`endif

[design/sed_pkg.sv]
// Shared types, character codes and helpers of the string escape decoder.
// No dependencies.
`timescale 1ns / 1ps

package sed_pkg;

  // Decoder modes
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_UNI    = 3'd2,
    MODE_OCT    = 3'd3
  } mode_e;

  // Character codes
  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQUOT = 8'h22;
  localparam logic [7:0] CH_SQUOT = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_R  = 8'h72;
  localparam logic [7:0] CH_LO_S  = 8'h73;
  localparam logic [7:0] CH_LO_T  = 8'h74;
  localparam logic [7:0] CH_LO_U  = 8'h75;

  localparam int unsigned UniDigits = 4;
  localparam int unsigned OctDigits = 3;
  localparam int unsigned FifoDepth = 4;

  // Decoder state carried between bytes
  typedef struct packed {
    mode_e       mode;
    logic [15:0] value;
    logic [2:0]  count;
    logic [1:0]  units;
    logic        wide;
  } state_t;

  // One result item
  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        final_flag;
    logic        too_long;
    logic        wide_flag;
  } result_t;

  localparam state_t StateReset = '{mode: MODE_NORMAL, value: '0, count: '0,
                                    units: '0, wide: 1'b0};

  // Hex digit decode: bit 4 flags a valid digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b inside {[8'h30:8'h39]}) r = {1'b1, b[3:0]};
    else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) r = {1'b1, b[3:0] + 4'd9};
    return r;
  endfunction

endpackage

[design/string_escape_decoder_top.sv]
// Top level of the string escape decoder: input register, decode step,
// result queue. Depends on sed_pkg and sed_decode.
//
//   channel | direction | handshake                  | payload
//   in      | input     | in_valid_i / in_stall_o    | char_byte_i
//   out     | output    | out_valid_o / out_stall_i  | code_unit_o, unit_valid_o,
//           |           |                            | final_flag_o, too_long_o, wide_flag_o
//
// One byte per cycle while in_stall_o is low: a byte waits in the input register,
// then its decode writes zero, one or two results into a four-entry queue.
// A byte's first result passes the input register, then the queue, before it is offered.
// Bytes that give two results can outrun the output, which drains one per cycle while
// out_stall_i is low; the input stalls while the queue holds more than two results.
// Reset (asynchronous, active low) returns the decoder to normal mode and empties the queue.
`timescale 1ns / 1ps

module string_escape_decoder_top import sed_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic        unit_valid_o,
  output logic        final_flag_o,
  output logic        too_long_o,
  output logic        wide_flag_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  state_t          state_q;
  state_t          state_d;
  result_t         res0;
  result_t         res1;
  logic [1:0]      nres;
  logic            advance;
  logic            pop;
  logic [1:0]      push_n;
  result_t         fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  result_t         head;

  // Decode step
  sed_decode u_decode (
    .cur_i  (state_q),
    .byte_i (in_byte_q),
    .nxt_o  (state_d),
    .res0_o (res0),
    .res1_o (res1),
    .nres_o (nres)
  );

  // Byte advances when the queue has room for two results
  assign advance    = in_valid_q && (count_q <= CntW'(FifoDepth - 2));
  assign in_stall_o = in_valid_q && !advance;
  assign push_n     = advance ? nres : 2'd0;
  assign pop        = out_valid_o && !out_stall_i;

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input byte payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= char_byte_i;
    end
  end

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= res1;
    end
  end

  // Result queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      if (pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      count_q <= count_q + CntW'(push_n) - CntW'(pop);
    end
  end

  // Output side
  assign head         = fifo_q[rd_ptr_q];
  assign out_valid_o  = count_q != '0;
  assign code_unit_o  = head.code_unit;
  assign unit_valid_o = head.unit_valid;
  assign final_flag_o = head.final_flag;
  assign too_long_o   = head.too_long;
  assign wide_flag_o  = head.wide_flag;

endmodule

[design/sed_decode.sv]
// Per-byte decode step: next state and up to two results from one byte.
// Depends on sed_pkg.
`timescale 1ns / 1ps

module sed_decode import sed_pkg::*; (
  input  state_t      cur_i,
  input  logic [7:0]  byte_i,
  output state_t      nxt_o,
  output result_t     res0_o,
  output result_t     res1_o,
  output logic [1:0]  nres_o
);

  state_t      nxt;
  logic        emit_a;
  logic [15:0] val_a;
  logic        emit_b;
  logic        do_plain;
  logic        fin;
  logic        end_esc;
  logic [4:0]  hex;
  logic [10:0] oct_nv;
  logic [15:0] uni_nv;
  logic [1:0]  units_a;
  result_t     ra;
  result_t     rb;

  assign hex    = hex_digit(byte_i);
  assign uni_nv = {cur_i.value[11:0], hex[3:0]};
  assign oct_nv = {cur_i.value[7:0], byte_i[2:0]};

  // Mode update and emission decisions
  always_comb begin
    nxt      = cur_i;
    emit_a   = 1'b0;
    val_a    = '0;
    emit_b   = 1'b0;
    do_plain = 1'b0;
    fin      = 1'b0;
    end_esc  = 1'b0;
    if (byte_i == CH_END) begin
      fin = 1'b1;
      if (cur_i.mode == MODE_UNI || cur_i.mode == MODE_OCT) begin
        emit_a = 1'b1;
        val_a  = cur_i.value;
      end
    end else begin
      case (cur_i.mode)
        MODE_ESC: begin
          nxt.mode = MODE_NORMAL;
          case (byte_i)
            CH_LO_B: begin emit_a = 1'b1; val_a = {8'h00, CH_BS}; end
            CH_LO_S: begin emit_a = 1'b1; val_a = {8'h00, CH_SPACE}; end
            CH_LO_T: begin emit_a = 1'b1; val_a = {8'h00, CH_TAB}; end
            CH_LO_N: begin emit_a = 1'b1; val_a = {8'h00, CH_LF}; end
            CH_LO_F: begin emit_a = 1'b1; val_a = {8'h00, CH_FF}; end
            CH_LO_R: begin emit_a = 1'b1; val_a = {8'h00, CH_CR}; end
            CH_DQUOT, CH_SQUOT, CH_BSL: begin
              emit_a = 1'b1;
              val_a  = {8'h00, byte_i};
            end
            CH_LO_U: begin
              nxt.mode  = MODE_UNI;
              nxt.value = '0;
              nxt.count = '0;
            end
            CH_CR, CH_LF: ;
            default: begin
              if (byte_i inside {[CH_ZERO:CH_SEVEN]}) begin
                nxt.mode  = MODE_OCT;
                nxt.value = {13'd0, byte_i[2:0]};
                nxt.count = 3'd1;
              end else begin
                // backslash before 8 or 9 yields a zero unit first
                emit_a   = (byte_i == CH_EIGHT) || (byte_i == CH_NINE);
                do_plain = 1'b1;
              end
            end
          endcase
        end
        MODE_UNI: begin
          if (byte_i == CH_LO_U && cur_i.count == 3'd0) begin
            // extra u after the backslash: skip
          end else if (hex[4] && cur_i.count < 3'(UniDigits)) begin
            nxt.value = uni_nv;
            nxt.wide  = cur_i.count >= 3'd2;
            nxt.count = cur_i.count + 3'd1;
            if (cur_i.count + 3'd1 >= 3'(UniDigits)) begin
              nxt.mode  = MODE_NORMAL;
              emit_a    = 1'b1;
              val_a     = uni_nv;
              nxt.value = '0;
              nxt.count = '0;
            end
          end else begin
            end_esc = 1'b1;
          end
        end
        MODE_OCT: begin
          if (byte_i inside {[CH_ZERO:CH_SEVEN]} && cur_i.count < 3'(OctDigits)
              && oct_nv[10:8] == 3'd0) begin
            nxt.value = {8'h00, oct_nv[7:0]};
            nxt.count = cur_i.count + 3'd1;
            if (cur_i.count + 3'd1 >= 3'(OctDigits)) begin
              nxt.mode  = MODE_NORMAL;
              emit_a    = 1'b1;
              val_a     = {8'h00, oct_nv[7:0]};
              nxt.value = '0;
              nxt.count = '0;
            end
          end else begin
            end_esc = 1'b1;
          end
        end
        default: begin
          nxt.mode = MODE_NORMAL;
          do_plain = 1'b1;
        end
      endcase

      // escape closed by this byte: flush its value, then decode the byte
      if (end_esc) begin
        nxt.mode  = MODE_NORMAL;
        emit_a    = 1'b1;
        val_a     = cur_i.value;
        nxt.value = '0;
        nxt.count = '0;
        do_plain  = 1'b1;
      end

      // plain byte handling
      if (do_plain) begin
        case (byte_i)
          CH_BSL: nxt.mode = MODE_ESC;
          CH_CR, CH_LF, CH_DQUOT, CH_SQUOT: ;
          default: emit_b = 1'b1;
        endcase
      end
    end
  end

  // Saturating unit count and result packing
  always_comb begin
    nxt_o   = nxt;
    units_a = cur_i.units;
    if (emit_a && units_a != 2'd2) units_a = units_a + 2'd1;
    ra = '{code_unit: val_a, unit_valid: 1'b1, final_flag: 1'b0,
           too_long: 1'b0, wide_flag: 1'b0};
    if (fin) begin
      rb    = '{code_unit: '0, unit_valid: 1'b0, final_flag: 1'b1,
                too_long: units_a == 2'd2, wide_flag: cur_i.wide};
      nxt_o = StateReset;
    end else begin
      rb = '{code_unit: {8'h00, byte_i}, unit_valid: 1'b1, final_flag: 1'b0,
             too_long: 1'b0, wide_flag: 1'b0};
      nxt_o.units = units_a;
      if (emit_b && nxt_o.units != 2'd2) nxt_o.units = nxt_o.units + 2'd1;
    end
  end

  logic second;
  assign second = fin || emit_b;
  assign res0_o = emit_a ? ra : rb;
  assign res1_o = rb;
  assign nres_o = {1'b0, emit_a} + {1'b0, second};

endmodule

[design/sed_checker.sv]
// Port-level checks of the string escape decoder, bound to the top level.
// Depends on string_escape_decoder_top_macros.svh.
`timescale 1ns / 1ps
`include "string_escape_decoder_top_macros.svh"

module sed_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] code_unit_o,
  input logic        unit_valid_o,
  input logic        final_flag_o,
  input logic        too_long_o,
  input logic        wide_flag_o
);

  // Closing result carries no unit
  `SED_ASSERT_NOW(a_final_no_unit, out_valid_o && final_flag_o, !unit_valid_o && code_unit_o == 16'h0000)

  // Unit results carry no literal flags
  `SED_ASSERT_NOW(a_unit_no_flags, out_valid_o && unit_valid_o, !final_flag_o && !too_long_o && !wide_flag_o)

  // Input only stalls when results are waiting
  `SED_ASSERT_NOW(a_stall_needs_backlog, !out_valid_o, !in_stall_o)

  // A stalled transfer keeps its result
  `SED_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(code_unit_o) && $stable(final_flag_o))

endmodule

bind string_escape_decoder_top sed_checker u_sed_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .code_unit_o  (code_unit_o),
  .unit_valid_o (unit_valid_o),
  .final_flag_o (final_flag_o),
  .too_long_o   (too_long_o),
  .wide_flag_o  (wide_flag_o)
);
